// File: rtl/core/iprc_pkg.sv
// shared types, codes and sizes of the ipsec policy range classifier
`default_nettype none
package iprc_pkg;

    localparam int MAX_POLICIES = 64;
    localparam int IW = (MAX_POLICIES > 1) ? $clog2(MAX_POLICIES) : 1;

    typedef logic [IW-1:0] slot_t;

    localparam logic [2:0] CMD_LOOKUP     = 3'd0;
    localparam logic [2:0] CMD_ADD        = 3'd1;
    localparam logic [2:0] CMD_DELETE     = 3'd2;
    localparam logic [2:0] CMD_BIND_SA    = 3'd3;
    localparam logic [2:0] CMD_DISABLE_SA = 3'd4;
    localparam logic [2:0] CMD_ENABLE_SA  = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_DUP_ID    = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    localparam logic [1:0] IPSEC_ACTION_BYPASS  = 2'd0;
    localparam logic [1:0] IPSEC_ACTION_DISCARD = 2'd2;
    localparam logic [1:0] IPSEC_ACTION_ILLEGAL = 2'd3;
    localparam logic [15:0] IPSEC_SA_INVALID    = 16'd0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] id;
        logic        outbound;
        logic [15:0] prio;
        logic [15:0] vrf;
        logic [31:0] src;
        logic [31:0] src_last;
        logic [31:0] dst;
        logic [31:0] dst_last;
        logic [7:0]  proto;
        logic [1:0]  action;
        logic [15:0] sa;
    } query_t;

    typedef struct packed {
        logic        best_found;
        logic [15:0] best_prio;
        slot_t       best_age;
        logic [1:0]  best_action;
        logic        best_sa_ok;
        logic [15:0] best_sa;
        logic        id_found;
        slot_t       id_slot;
        slot_t       id_age;
        logic        free_found;
        slot_t       free_slot;
    } accum_t;

    typedef struct packed {
        logic  add;
        logic  del;
        logic  sa_bind;
        logic  dis;
        logic  en;
        slot_t slot;
        slot_t age;
    } upd_t;

endpackage
`default_nettype wire

// File: rtl/core/iprc_cell.sv
// one policy entry of the chain: local match, running best and table update
`default_nettype none
module iprc_cell
    import iprc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire slot_t  cell_idx,
    input  wire query_t query,
    input  wire upd_t   upd,
    input  wire accum_t acc_in,
    output accum_t      acc_out
);

    logic        valid_reg, valid_next;
    logic [31:0] id_reg, id_next;
    logic [15:0] sa_reg, sa_next;
    logic [31:0] sf_reg, sf_next, sl_reg, sl_next;
    logic [31:0] df_reg, df_next, dl_reg, dl_next;
    logic [15:0] prio_reg, prio_next;
    logic [15:0] vrf_reg, vrf_next;
    logic [7:0]  proto_reg, proto_next;
    logic [1:0]  act_reg, act_next;
    logic        outb_reg, outb_next;
    logic        bound_reg, bound_next;
    logic        dis_reg, dis_next;
    slot_t       age_reg, age_next;
    accum_t      acc_reg, acc_next;
    logic        match, take, here;

    assign here = (cell_idx == upd.slot);

    always_comb
    begin
        match = valid_reg && (outb_reg == query.outbound) && (vrf_reg == query.vrf)
            && (query.src >= sf_reg) && (query.src <= sl_reg)
            && (query.dst >= df_reg) && (query.dst <= dl_reg)
            && ((proto_reg == 8'd0) || (proto_reg == query.proto));
        take = match && (!acc_in.best_found || (prio_reg < acc_in.best_prio)
            || ((prio_reg == acc_in.best_prio) && (age_reg < acc_in.best_age)));
        acc_next = acc_in;
        if (take)
        begin
            acc_next.best_found  = 1'b1;
            acc_next.best_prio   = prio_reg;
            acc_next.best_age    = age_reg;
            acc_next.best_action = act_reg;
            acc_next.best_sa_ok  = bound_reg && !dis_reg;
            acc_next.best_sa     = sa_reg;
        end
        if (valid_reg && (id_reg == query.id) && !acc_in.id_found)
        begin
            acc_next.id_found = 1'b1;
            acc_next.id_slot  = cell_idx;
            acc_next.id_age   = age_reg;
        end
        if (!valid_reg && !acc_in.free_found)
        begin
            acc_next.free_found = 1'b1;
            acc_next.free_slot  = cell_idx;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        sa_next    = sa_reg;
        sf_next    = sf_reg;
        sl_next    = sl_reg;
        df_next    = df_reg;
        dl_next    = dl_reg;
        prio_next  = prio_reg;
        vrf_next   = vrf_reg;
        proto_next = proto_reg;
        act_next   = act_reg;
        outb_next  = outb_reg;
        bound_next = bound_reg;
        dis_next   = dis_reg;
        age_next   = age_reg;
        if (upd.add)
        begin
            if (valid_reg)
            begin
                age_next = age_reg + slot_t'(1);
            end
            if (here)
            begin
                valid_next = 1'b1;
                id_next    = query.id;
                sf_next    = query.src;
                sl_next    = query.src_last;
                df_next    = query.dst;
                dl_next    = query.dst_last;
                prio_next  = query.prio;
                vrf_next   = query.vrf;
                proto_next = query.proto;
                act_next   = query.action;
                outb_next  = query.outbound;
                bound_next = 1'b0;
                dis_next   = 1'b0;
                age_next   = '0;
            end
        end
        if (upd.del)
        begin
            if (here)
            begin
                valid_next = 1'b0;
            end
            else if (valid_reg && (age_reg > upd.age))
            begin
                age_next = age_reg - slot_t'(1);
            end
        end
        if (upd.sa_bind && here)
        begin
            sa_next    = query.sa;
            bound_next = 1'b1;
            dis_next   = 1'b0;
        end
        if (upd.dis && here)
        begin
            dis_next = 1'b1;
        end
        if (upd.en && here)
        begin
            dis_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        sa_reg    <= sa_next;
        sf_reg    <= sf_next;
        sl_reg    <= sl_next;
        df_reg    <= df_next;
        dl_reg    <= dl_next;
        prio_reg  <= prio_next;
        vrf_reg   <= vrf_next;
        proto_reg <= proto_next;
        act_reg   <= act_next;
        outb_reg  <= outb_next;
        bound_reg <= bound_next;
        dis_reg   <= dis_next;
        age_reg   <= age_next;
        acc_reg   <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule
`default_nettype wire

// File: rtl/core/ipsec_policy_range_classifier.sv
// top level of the ipsec policy range classifier: command sequencer and cell chain
`default_nettype none
// Each command word is taken when the block is idle: the search walks the chain of policy
// cells one cell per cycle, carrying the best match, the id hit and the first free slot,
// then the apply state applies the table update to all cells and the done state registers
// the result once the output is free. The next word can be taken while a finished result
// still waits on the output.
module ipsec_policy_range_classifier
    import iprc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [31:0] policy_id,
    input  wire logic        outbound,
    input  wire logic [15:0] priority_req,
    input  wire logic [15:0] vrf,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] src_last,
    input  wire logic [31:0] dst_ip,
    input  wire logic [31:0] dst_last,
    input  wire logic [7:0]  protocol,
    input  wire logic [1:0]  policy_action,
    input  wire logic [15:0] sa_handle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             matched,
    output logic [1:0]       result_action,
    output logic             sa_valid,
    output logic [15:0]      sa_out
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_DONE} state_t;

    state_t      state_reg, state_next;
    slot_t       cnt_reg, cnt_next;
    query_t      query_reg, query_next;
    logic        ov_reg, ov_next;
    logic [1:0]  st_reg, st_next, rs_st_reg, rs_st_next;
    logic        mt_reg, mt_next, rs_mt_reg, rs_mt_next;
    logic [1:0]  ac_reg, ac_next, rs_ac_reg, rs_ac_next;
    logic        sv_reg, sv_next, rs_sv_reg, rs_sv_next;
    logic [15:0] so_reg, so_next, rs_so_reg, rs_so_next;
    upd_t        upd;
    accum_t      acc_init;
    accum_t      acc [MAX_POLICIES];
    accum_t      last;

    assign acc_init = '0;
    assign last = acc[MAX_POLICIES-1];

    genvar k;
    generate
        for (k = 0; k < MAX_POLICIES; k++)
        begin : g_cell
            iprc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (slot_t'(k)),
                .query    (query_reg),
                .upd      (upd),
                .acc_in   ((k == 0) ? acc_init : acc[(k == 0) ? 0 : k-1]),
                .acc_out  (acc[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        query_next = query_reg;
        ov_next    = ov_reg;
        st_next    = st_reg;
        mt_next    = mt_reg;
        ac_next    = ac_reg;
        sv_next    = sv_reg;
        so_next    = so_reg;
        rs_st_next = rs_st_reg;
        rs_mt_next = rs_mt_reg;
        rs_ac_next = rs_ac_reg;
        rs_sv_next = rs_sv_reg;
        rs_so_next = rs_so_reg;
        upd        = '0;
        upd.slot   = last.id_slot;
        upd.age    = last.id_age;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    query_next.cmd      = command;
                    query_next.id       = policy_id;
                    query_next.outbound = outbound;
                    query_next.prio     = priority_req;
                    query_next.vrf      = vrf;
                    query_next.src      = src_ip;
                    query_next.src_last = src_last;
                    query_next.dst      = dst_ip;
                    query_next.dst_last = dst_last;
                    query_next.proto    = protocol;
                    query_next.action   = (policy_action == IPSEC_ACTION_ILLEGAL)
                                          ? IPSEC_ACTION_DISCARD : policy_action;
                    query_next.sa       = sa_handle;
                    cnt_next            = '0;
                    state_next          = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + slot_t'(1);
                if (cnt_reg == slot_t'(MAX_POLICIES - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                rs_st_next = STATUS_OK;
                rs_mt_next = 1'b0;
                rs_ac_next = IPSEC_ACTION_BYPASS;
                rs_sv_next = 1'b0;
                rs_so_next = IPSEC_SA_INVALID;
                case (query_reg.cmd)
                    CMD_LOOKUP:
                    begin
                        if (last.best_found)
                        begin
                            rs_mt_next = 1'b1;
                            rs_ac_next = last.best_action;
                            if (query_reg.outbound && last.best_sa_ok)
                            begin
                                rs_sv_next = 1'b1;
                                rs_so_next = last.best_sa;
                            end
                        end
                    end
                    CMD_ADD:
                    begin
                        if (last.id_found)
                        begin
                            rs_st_next = STATUS_DUP_ID;
                        end
                        else if (!last.free_found)
                        begin
                            rs_st_next = STATUS_FULL;
                        end
                        else
                        begin
                            upd.add  = 1'b1;
                            upd.slot = last.free_slot;
                        end
                    end
                    CMD_DELETE, CMD_BIND_SA, CMD_DISABLE_SA, CMD_ENABLE_SA:
                    begin
                        if (!last.id_found)
                        begin
                            rs_st_next = STATUS_NOT_FOUND;
                        end
                        else
                        begin
                            upd.del     = (query_reg.cmd == CMD_DELETE);
                            upd.sa_bind = (query_reg.cmd == CMD_BIND_SA);
                            upd.dis     = (query_reg.cmd == CMD_DISABLE_SA);
                            upd.en      = (query_reg.cmd == CMD_ENABLE_SA);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    st_next    = rs_st_reg;
                    mt_next    = rs_mt_reg;
                    ac_next    = rs_ac_reg;
                    sv_next    = rs_sv_reg;
                    so_next    = rs_so_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        query_reg <= query_next;
        st_reg    <= st_next;
        mt_reg    <= mt_next;
        ac_reg    <= ac_next;
        sv_reg    <= sv_next;
        so_reg    <= so_next;
        rs_st_reg <= rs_st_next;
        rs_mt_reg <= rs_mt_next;
        rs_ac_reg <= rs_ac_next;
        rs_sv_reg <= rs_sv_next;
        rs_so_reg <= rs_so_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign matched       = mt_reg;
    assign result_action = ac_reg;
    assign sa_valid      = sv_reg;
    assign sa_out        = so_reg;

endmodule
`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench of the ipsec policy range classifier
module testbench
    import iprc_pkg::*;
();

    localparam int LIMIT = 1000000;
    localparam int N_RANDOM = 1460;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] id;
        logic        dir;
        logic [15:0] prio;
        logic [15:0] vrf;
        logic [31:0] src;
        logic [31:0] srcl;
        logic [31:0] dst;
        logic [31:0] dstl;
        logic [7:0]  proto;
        logic [1:0]  act;
        logic [15:0] sa;
    } word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        matched;
        logic [1:0]  action;
        logic        sa_valid;
        logic [15:0] sa;
    } verdict_t;

    typedef struct {
        word_t    w;
        bit       typed;
        verdict_t v;
    } row_t;

    typedef struct {
        bit          used;
        logic [31:0] id;
        logic [15:0] sa;
        logic [31:0] sf, sl, df, dl;
        logic [15:0] prio, vrf;
        logic [7:0]  proto;
        logic [1:0]  act;
        logic        dir, bound, dis;
        int          age;
    } policy_t;

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_ready, out_valid, out_ready = 0;
    logic [2:0] command = 0;
    logic [31:0] policy_id = 0, src_ip = 0, src_last = 0, dst_ip = 0, dst_last = 0;
    logic outbound = 0;
    logic [15:0] priority_req = 0, vrf = 0, sa_handle = 0;
    logic [7:0] protocol = 0;
    logic [1:0] policy_action = 0;
    logic [1:0] status, result_action;
    logic matched, sa_valid;
    logic [15:0] sa_out;

    policy_t  spd [MAX_POLICIES];
    verdict_t pending_verdicts [$];
    row_t     rows [$];
    int errors = 0, checked = 0, cycles = 0, sent = 0;
    int tx_idle = 0, rx_idle = 0, hold_cycles = 0;
    int matches_seen = 0, full_seen = 0;

    ipsec_policy_range_classifier dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int find_id(logic [31:0] id);
        for (int i = 0; i < MAX_POLICIES; i++)
            if (spd[i].used && spd[i].id == id)
                return i;
        return -1;
    endfunction

    function automatic verdict_t classify(word_t w);
        verdict_t v;
        int s, best;
        logic [1:0] a;
        v = '0;
        best = -1;
        a = (w.act == IPSEC_ACTION_ILLEGAL) ? IPSEC_ACTION_DISCARD : w.act;
        case (w.cmd)
            CMD_LOOKUP:
            begin
                for (int i = 0; i < MAX_POLICIES; i++)
                begin
                    if (!spd[i].used || spd[i].dir != w.dir || spd[i].vrf != w.vrf) continue;
                    if (w.src < spd[i].sf || w.src > spd[i].sl) continue;
                    if (w.dst < spd[i].df || w.dst > spd[i].dl) continue;
                    if (spd[i].proto != 0 && spd[i].proto != w.proto) continue;
                    if (best < 0 || spd[i].prio < spd[best].prio
                        || (spd[i].prio == spd[best].prio && spd[i].age < spd[best].age))
                        best = i;
                end
                if (best >= 0)
                begin
                    v.matched = 1;
                    v.action = spd[best].act;
                    if (w.dir && spd[best].bound && !spd[best].dis)
                    begin
                        v.sa_valid = 1;
                        v.sa = spd[best].sa;
                    end
                end
            end
            CMD_ADD:
            begin
                s = -1;
                for (int i = MAX_POLICIES - 1; i >= 0; i--)
                    if (!spd[i].used) s = i;
                if (find_id(w.id) >= 0) v.status = STATUS_DUP_ID;
                else if (s < 0) v.status = STATUS_FULL;
                else
                begin
                    for (int i = 0; i < MAX_POLICIES; i++)
                        if (spd[i].used) spd[i].age++;
                    spd[s] = '{1'b1, w.id, 16'd0, w.src, w.srcl, w.dst, w.dstl,
                               w.prio, w.vrf, w.proto, a, w.dir, 1'b0, 1'b0, 0};
                end
            end
            CMD_DELETE, CMD_BIND_SA, CMD_DISABLE_SA, CMD_ENABLE_SA:
            begin
                s = find_id(w.id);
                if (s < 0) v.status = STATUS_NOT_FOUND;
                else if (w.cmd == CMD_DELETE)
                begin
                    spd[s].used = 0;
                    for (int i = 0; i < MAX_POLICIES; i++)
                        if (spd[i].used && spd[i].age > spd[s].age) spd[i].age--;
                end
                else if (w.cmd == CMD_BIND_SA)
                begin
                    spd[s].sa = w.sa;
                    spd[s].bound = 1;
                    spd[s].dis = 0;
                end
                else
                    spd[s].dis = (w.cmd == CMD_DISABLE_SA);
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic word_t mk(logic [2:0] cmd, logic [31:0] id, logic dir,
                                 logic [15:0] prio, logic [15:0] vr, logic [31:0] sf,
                                 logic [31:0] sl, logic [31:0] df, logic [31:0] dl,
                                 logic [7:0] proto, logic [1:0] act, logic [15:0] sa);
        word_t w;
        w = '{cmd, id, dir, prio, vr, sf, sl, df, dl, proto, act, sa};
        return w;
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 2))
            0: return 32'h0000_0000;
            1: return 32'hC0A8_0000;
            default: return 32'hFFFF_FF00;
        endcase
    endfunction

    function automatic word_t random_word();
        word_t w;
        int r;
        logic [31:0] b;
        w = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom);
        r = $urandom_range(0, 99);
        if (r < 40) w.cmd = CMD_LOOKUP;
        else if (r < 65) w.cmd = CMD_ADD;
        else if (r < 77) w.cmd = CMD_DELETE;
        else if (r < 85) w.cmd = CMD_BIND_SA;
        else if (r < 90) w.cmd = CMD_DISABLE_SA;
        else if (r < 95) w.cmd = CMD_ENABLE_SA;
        else w.cmd = $urandom_range(6, 7);
        if ($urandom_range(0, 9) != 0) w.id = $urandom_range(0, 79);
        if ($urandom_range(0, 9) != 0) w.vrf = $urandom_range(0, 2);
        if ($urandom_range(0, 9) != 0) w.prio = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0: w.proto = 0;
            1: w.proto = 6;
            2: w.proto = 17;
            default: ;
        endcase
        if ($urandom_range(0, 9) != 0)
        begin
            b = pick_base();
            if (w.cmd == CMD_ADD)
            begin
                w.src = b + $urandom_range(0, 64);
                w.srcl = w.src + $urandom_range(0, 160) - 8;
                w.dst = b + $urandom_range(0, 64);
                w.dstl = w.dst + $urandom_range(0, 160) - 8;
            end
            else
            begin
                w.src = b + $urandom_range(0, 200);
                w.dst = b + $urandom_range(0, 200);
            end
        end
        return w;
    endfunction

    task automatic send(word_t w);
        int gap;
        @(negedge clk);
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle && gap < 50)
        begin
            gap++;
            @(negedge clk);
        end
        command = w.cmd; policy_id = w.id; outbound = w.dir; priority_req = w.prio;
        vrf = w.vrf; src_ip = w.src; src_last = w.srcl; dst_ip = w.dst;
        dst_last = w.dstl; protocol = w.proto; policy_action = w.act; sa_handle = w.sa;
        in_valid = 1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 0;
        sent++;
    endtask

    task automatic issue(word_t w, bit typed, verdict_t tv);
        verdict_t v;
        send(w);
        v = classify(w);
        pending_verdicts.push_back(typed ? tv : v);
    endtask

    task automatic add_row(word_t w, bit typed, verdict_t v);
        row_t r;
        r.w = w; r.typed = typed; r.v = v;
        rows.push_back(r);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready = 0;
        end
        else
            out_ready = rst_n && ($urandom_range(0, 99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        verdict_t e, g;
        if (out_valid && out_ready)
        begin
            g = '{status, matched, result_action, sa_valid, sa_out};
            checked++;
            if (g.matched) matches_seen++;
            if (g.status == STATUS_FULL) full_seen++;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected word: %p", g);
            end
            else
            begin
                e = pending_verdicts.pop_front();
                if (e.status != g.status || e.matched != g.matched || e.action != g.action
                    || e.sa_valid != g.sa_valid || e.sa != g.sa)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at word %0d: expected %p, got %p", checked, e, g);
                end
            end
        end
    end

    initial
    begin
        word_t w;
        int waited;
        verdict_t z;
        z = '0;
        foreach (spd[i]) spd[i].used = 0;
        // directed
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(CMD_ADD, 0, 1, 5, 0, 0, '1, 0, '1, 0, 3, 0), 1, z);
        add_row(mk(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                '{STATUS_DUP_ID, 1'b0, 2'd0, 1'b0, 16'd0});
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, '1, 0, 0, 0, 255, 0, 0), 1,
                '{STATUS_OK, 1'b1, IPSEC_ACTION_DISCARD, 1'b0, 16'd0});
        add_row(mk(CMD_BIND_SA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, 5, 0, 9, 0, 6, 0, 0), 1,
                '{STATUS_OK, 1'b1, IPSEC_ACTION_DISCARD, 1'b1, 16'd0});
        add_row(mk(CMD_BIND_SA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1), 0, z);
        add_row(mk(CMD_DISABLE_SA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, 5, 0, 9, 0, 6, 0, 0), 0, z);
        add_row(mk(CMD_ENABLE_SA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, 5, 0, 9, 0, 6, 0, 0), 0, z);
        add_row(mk(CMD_LOOKUP, 0, 0, 0, 0, 5, 0, 9, 0, 6, 0, 0), 0, z);
        add_row(mk(CMD_DELETE, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                '{STATUS_NOT_FOUND, 1'b0, 2'd0, 1'b0, 16'd0});
        add_row(mk(CMD_BIND_SA, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                '{STATUS_NOT_FOUND, 1'b0, 2'd0, 1'b0, 16'd0});
        add_row(mk(CMD_DISABLE_SA, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                '{STATUS_NOT_FOUND, 1'b0, 2'd0, 1'b0, 16'd0});
        add_row(mk(CMD_ENABLE_SA, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                '{STATUS_NOT_FOUND, 1'b0, 2'd0, 1'b0, 16'd0});
        add_row(mk(3'd6, '1, 1, '1, '1, '1, '1, '1, '1, '1, 3, '1), 1, z);
        add_row(mk(3'd7, 0, 1, 0, 0, 5, 0, 9, 0, 6, 0, 0), 1, z);
        add_row(mk(CMD_ADD, 5, 1, 0, 0, 20, 10, 0, '1, 0, 1, 0), 0, z);
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, 15, 0, 9, 0, 6, 0, 0), 0, z);
        add_row(mk(CMD_ADD, 7, 1, 5, 0, 0, 100, 0, 100, 6, 1, 0), 0, z);
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, 50, 0, 50, 0, 6, 0, 0), 0, z);
        add_row(mk(CMD_LOOKUP, 0, 1, 0, 0, 50, 0, 50, 0, 17, 0, 0), 0, z);
        add_row(mk(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        tx_idle = 19;
        rx_idle = 59;
        foreach (rows[i]) issue(rows[i].w, rows[i].typed, rows[i].v);
        // fill the table, then one add past full
        for (int i = 0; i < MAX_POLICIES - 1; i++)
        begin
            w = random_word();
            w.cmd = CMD_ADD;
            w.id = 1000 + i;
            issue(w, 0, z);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                tx_idle = 59;
                rx_idle = 19;
            end
            if (n == 2 * N_RANDOM / 3)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (n == 300) hold_cycles = 600;
            if (n == 700)
                while (pending_verdicts.size() != 0) @(posedge clk);
            w = random_word();
            if (n < 200 && w.cmd == CMD_ADD) w.id = 1000 + $urandom_range(0, 79);
            issue(w, 0, z);
        end
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < 20000)
        begin
            waited++;
            @(posedge clk);
        end
        repeat (2 * MAX_POLICIES + 20) @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d lookups matched, %0d adds refused full",
                 sent, checked, matches_seen, full_seen);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d mismatches, %0d results missing", errors, pending_verdicts.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
